FILE: src/tadm_pkg.sv
// Shared types, widths, register codes and the grading helper function of the temperature alarm monitor.
package tadm_pkg;

   localparam int TEMP_W              = 12;
   localparam int SPD_W               = 7;
   localparam int MINUTES_W           = 6;
   localparam int LIMIT_W             = 6;
   localparam int COUNT_OUT_W         = 7;
   localparam int ALERT_W             = 12;
   localparam int DATE_W              = 9;
   localparam int DAY_W               = 5;
   localparam int MONTH_W             = 4;
   localparam int CSR_W               = 12;
   localparam int CSR_IDX_W           = 3;
   localparam int DEFAULT_MAX_SAMPLES = 64;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_LOW_THRESHOLD     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_THRESHOLD    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLES_PER_DAY   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_MINUTES    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAINTENANCE_LIMIT = 3'd4;

   localparam logic signed [TEMP_W-1:0] LOW_THRESHOLD_RST     = 12'sd80;
   localparam logic signed [TEMP_W-1:0] HIGH_THRESHOLD_RST    = 12'sd640;
   localparam logic [SPD_W-1:0]         SAMPLES_PER_DAY_RST   = 7'd48;
   localparam logic [MINUTES_W-1:0]     SAMPLE_MINUTES_RST    = 6'd30;
   localparam logic [LIMIT_W-1:0]       MAINTENANCE_LIMIT_RST = 6'd5;

   // Severity grades
   localparam logic [1:0] SEV_FINE     = 2'd0;
   localparam logic [1:0] SEV_SIMPLE   = 2'd1;
   localparam logic [1:0] SEV_MODERATE = 2'd2;
   localparam logic [1:0] SEV_CRITICAL = 2'd3;

   localparam logic [8:0] MODERATE_FROM  = 9'd5;
   localparam logic [8:0] CRITICAL_ABOVE = 9'd10;

   localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;

   localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
      5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GRADE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_EMIT
   } tadm_state_type;

   typedef struct packed {
      logic [1:0]                severity;
      logic                      false_alarm;
      logic                      report_valid;
      logic [DATE_W-1:0]         report_date;
      logic signed [TEMP_W-1:0]  mean_temp;
      logic signed [TEMP_W-1:0]  min_temp;
      logic signed [TEMP_W-1:0]  max_temp;
      logic [COUNT_OUT_W-1:0]    critical_count;
      logic [COUNT_OUT_W-1:0]    moderate_count;
      logic [COUNT_OUT_W-1:0]    simple_count;
      logic [ALERT_W-1:0]        alert_minutes;
      logic                      maintenance;
   } rsp_type;

   // Grade one sample against the band; the low edge is tested first.
   function automatic logic [1:0] grade_of(input logic signed [TEMP_W-1:0] t,
                                           input logic signed [TEMP_W-1:0] lo,
                                           input logic signed [TEMP_W-1:0] hi);
      logic signed [TEMP_W:0] d;
      logic [TEMP_W:0]        mag;
      logic [8:0]             k;
      if (t >= lo && t <= hi) begin
         return SEV_FINE;
      end
      if (t < lo) begin
         d = $signed({lo[TEMP_W-1], lo}) - $signed({t[TEMP_W-1], t});
      end else begin
         d = $signed({hi[TEMP_W-1], hi}) - $signed({t[TEMP_W-1], t});
      end
      mag = d[TEMP_W] ? $unsigned(-d) : $unsigned(d);
      k   = mag[TEMP_W:4];
      if (k < MODERATE_FROM) begin
         return SEV_SIMPLE;
      end
      if (k <= CRITICAL_ABOVE) begin
         return SEV_MODERATE;
      end
      return SEV_CRITICAL;
   endfunction

endpackage

FILE: src/tadm_req_if.sv
// Sample channel: valid/ready handshake carrying one temperature.
interface tadm_req_if import tadm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature;

   modport source (output valid, output temperature, input ready);
   modport sink   (input valid, input temperature, output ready);
endinterface

FILE: src/tadm_rsp_if.sv
// Result channel: valid/ready handshake carrying grade and daily report.
interface tadm_rsp_if import tadm_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/tadm_divider.sv
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
module tadm_divider #(
   parameter int DVD_W = 18,
   parameter int DVS_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         step_in = STEP_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : DVS_W'(trial);
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/temperature_alarm_daily_monitor_unit.sv
// Temperature alarm monitor: grades samples, keeps daily statistics, reports each day.
//
// req_chan carries one temperature sample (1/16 degree, signed) per transaction.
// rsp_chan returns exactly one result per sample: severity grade, false alarm
// flag and, on the day's last sample, the daily report (date, mean, min, max,
// grade counts, alert minutes, maintenance flag); report fields are zero otherwise.
// csr_write/csr_index/csr_data write the thresholds, day length, sample minutes
// and maintenance limit; write them only while the block is idle.
// After a sample is accepted it passes ST_GRADE, ST_UPDATE and ST_EMIT, where its
// result is registered for rsp_chan, and the next sample is taken back in ST_IDLE;
// the day's last sample also passes ST_DIVIDE, where the serial divider forms the
// mean one quotient bit per cycle before ST_EMIT.
// req_chan.ready is high only while no sample is in work, so one sample is
// in flight at a time; a finished result sits in the output register while
// the next sample is taken, and a sample finishing before that register
// drains waits for rsp_chan.ready.
// Reset (synchronous) restores register defaults, clears the day and sets
// the date to January 1.
module temperature_alarm_daily_monitor_unit import tadm_pkg::*; #(
   parameter int MAX_SAMPLES = DEFAULT_MAX_SAMPLES
) (
   input  logic                 clock,
   input  logic                 reset,
   tadm_req_if.sink             req_chan,
   tadm_rsp_if.source           rsp_chan,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int IDX_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = TEMP_W + IDX_W;
   localparam logic [SPD_W-1:0] MAX_N = SPD_W'(MAX_SAMPLES);

   tadm_state_type state_ff, state_in;

   logic signed [TEMP_W-1:0] low_ff, low_in, high_ff, high_in;
   logic [SPD_W-1:0]         spd_ff, spd_in;
   logic [MINUTES_W-1:0]     minutes_ff, minutes_in;
   logic [LIMIT_W-1:0]       limit_ff, limit_in;

   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [1:0]               grade_ff, grade_in;
   logic [1:0]               hist0_ff, hist0_in, hist1_ff, hist1_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [TEMP_W-1:0] min_ff, min_in, max_ff, max_in;
   logic [CNT_W-1:0]         crit_ff, crit_in, mod_ff, mod_in, simp_ff, simp_in;
   logic [CNT_W-1:0]         alert_ff, alert_in, false_ff, false_in;
   logic [DAY_W-1:0]         day_ff, day_in;
   logic [MONTH_W-1:0]       month_ff, month_in;
   logic                     neg_ff, neg_in;
   rsp_type                  res_ff, res_in, out_ff, out_in;
   logic                     out_valid_ff, out_valid_in;

   // update-step intermediates
   logic                          fa;
   logic signed [SUM_W-1:0]       sum_new;
   logic signed [TEMP_W-1:0]      min_new, max_new;
   logic [CNT_W-1:0]              crit_new, mod_new, simp_new, alert_new, false_new;
   logic [CNT_W-1:0]              count;
   logic [SPD_W-1:0]              n_eff;
   logic                          report;
   logic [CNT_W+MINUTES_W-1:0]    alert_prod;
   logic [DAY_W:0]                day_next;
   logic [TEMP_W-1:0]             q_low;

   logic                          div_start;
   logic [SUM_W-1:0]              div_dividend;
   logic                          div_done;
   logic [SUM_W-1:0]              div_quotient;

   tadm_divider #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Configuration register writes
   always_comb begin
      low_in     = low_ff;
      high_in    = high_ff;
      spd_in     = spd_ff;
      minutes_in = minutes_ff;
      limit_in   = limit_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_LOW_THRESHOLD:     low_in     = $signed(csr_data[TEMP_W-1:0]);
            REG_HIGH_THRESHOLD:    high_in    = $signed(csr_data[TEMP_W-1:0]);
            REG_SAMPLES_PER_DAY:   spd_in     = csr_data[SPD_W-1:0];
            REG_SAMPLE_MINUTES:    minutes_in = csr_data[MINUTES_W-1:0];
            REG_MAINTENANCE_LIMIT: limit_in   = csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Statistics for the sample in temp_ff/grade_ff
   always_comb begin
      fa = (grade_ff != SEV_FINE) && (hist0_ff == grade_ff) && (hist1_ff == grade_ff);
      sum_new = sum_ff + $signed({{(SUM_W-TEMP_W){temp_ff[TEMP_W-1]}}, temp_ff});
      if (idx_ff == '0) begin
         min_new = temp_ff;
         max_new = temp_ff;
      end else begin
         min_new = (temp_ff < min_ff) ? temp_ff : min_ff;
         max_new = (temp_ff > max_ff) ? temp_ff : max_ff;
      end
      crit_new  = crit_ff + CNT_W'(grade_ff == SEV_CRITICAL);
      mod_new   = mod_ff + CNT_W'(grade_ff == SEV_MODERATE);
      simp_new  = simp_ff + CNT_W'(grade_ff == SEV_SIMPLE);
      alert_new = alert_ff + CNT_W'(grade_ff != SEV_FINE);
      false_new = false_ff + CNT_W'(fa);
      count     = CNT_W'(idx_ff) + 1'b1;
      if (spd_ff == '0) begin
         n_eff = SPD_W'(1);
      end else if (spd_ff > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = spd_ff;
      end
      report       = SPD_W'(count) >= n_eff;
      alert_prod   = CNT_W'(alert_new) * (CNT_W+MINUTES_W)'(minutes_ff);
      day_next     = {1'b0, day_ff} + 1'b1;
      div_dividend = sum_new[SUM_W-1] ? $unsigned(-sum_new) : $unsigned(sum_new);
      q_low        = div_quotient[TEMP_W-1:0];
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      temp_in      = temp_ff;
      grade_in     = grade_ff;
      hist0_in     = hist0_ff;
      hist1_in     = hist1_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      crit_in      = crit_ff;
      mod_in       = mod_ff;
      simp_in      = simp_ff;
      alert_in     = alert_ff;
      false_in     = false_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      div_start    = 1'b0;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               temp_in  = req_chan.temperature;
               state_in = ST_GRADE;
            end
         end
         ST_GRADE: begin
            grade_in = grade_of(temp_ff, low_ff, high_ff);
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            res_in              = '0;
            res_in.severity     = grade_ff;
            res_in.false_alarm  = fa;
            res_in.report_valid = report;
            if (report) begin
               res_in.report_date    = {month_ff, day_ff};
               res_in.min_temp       = min_new;
               res_in.max_temp       = max_new;
               res_in.critical_count = COUNT_OUT_W'(crit_new);
               res_in.moderate_count = COUNT_OUT_W'(mod_new);
               res_in.simple_count   = COUNT_OUT_W'(simp_new);
               res_in.alert_minutes  = ALERT_W'(alert_prod);
               res_in.maintenance    = 8'(false_new) > 8'(limit_ff);
               neg_in    = sum_new[SUM_W-1];
               div_start = 1'b1;
               // clear the day, advance the date
               idx_in   = '0;
               hist0_in = SEV_FINE;
               hist1_in = SEV_FINE;
               sum_in   = '0;
               min_in   = '0;
               max_in   = '0;
               crit_in  = '0;
               mod_in   = '0;
               simp_in  = '0;
               alert_in = '0;
               false_in = '0;
               if (day_next > {1'b0, MONTH_LEN[month_ff]}) begin
                  day_in   = DAY_W'(1);
                  month_in = (month_ff >= LAST_MONTH) ? MONTH_W'(1) : month_ff + 1'b1;
               end else begin
                  day_in = DAY_W'(day_next);
               end
               state_in = ST_DIVIDE;
            end else begin
               idx_in   = count[IDX_W-1:0];
               hist0_in = grade_ff;
               hist1_in = hist0_ff;
               sum_in   = sum_new;
               min_in   = min_new;
               max_in   = max_new;
               crit_in  = crit_new;
               mod_in   = mod_new;
               simp_in  = simp_new;
               alert_in = alert_new;
               false_in = false_new;
               state_in = ST_EMIT;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               res_in.mean_temp = neg_ff ? $signed(-q_low) : $signed(q_low);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_chan.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= LOW_THRESHOLD_RST;
         high_ff      <= HIGH_THRESHOLD_RST;
         spd_ff       <= SAMPLES_PER_DAY_RST;
         minutes_ff   <= SAMPLE_MINUTES_RST;
         limit_ff     <= MAINTENANCE_LIMIT_RST;
         hist0_ff     <= SEV_FINE;
         hist1_ff     <= SEV_FINE;
         idx_ff       <= '0;
         sum_ff       <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         crit_ff      <= '0;
         mod_ff       <= '0;
         simp_ff      <= '0;
         alert_ff     <= '0;
         false_ff     <= '0;
         day_ff       <= DAY_W'(1);
         month_ff     <= MONTH_W'(1);
         out_valid_ff <= 1'b0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         spd_ff       <= spd_in;
         minutes_ff   <= minutes_in;
         limit_ff     <= limit_in;
         hist0_ff     <= hist0_in;
         hist1_ff     <= hist1_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         crit_ff      <= crit_in;
         mod_ff       <= mod_in;
         simp_ff      <= simp_in;
         alert_ff     <= alert_in;
         false_ff     <= false_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         out_valid_ff <= out_valid_in;
      end
      temp_ff  <= temp_in;
      grade_ff <= grade_in;
      neg_ff   <= neg_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_ff;

endmodule
